// ===== rtl/piecewise_linear_inverse_cdf_sampler_core_macros.svh =====
// Assertion helpers for the sampler checker.
`ifndef PIECEWISE_LINEAR_INVERSE_CDF_SAMPLER_CORE_MACROS_SVH
`define PIECEWISE_LINEAR_INVERSE_CDF_SAMPLER_CORE_MACROS_SVH

// Checked only while out of reset.
`define PWLCDF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pwlcdf check failed");

// Checked on every edge, reset included.
`define PWLCDF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("pwlcdf check failed");

`endif

// ===== rtl/pwlcdf_pkg.sv =====
`timescale 1ns / 1ps

package pwlcdf_pkg;

  localparam int MAX_POINTS_DEF = 512;
  localparam int NUM_TABLES_DEF = 3;

  localparam int DIV_NW = 64;
  localparam int DIV_DW = 33;
  localparam int RAD_W  = 84;
  localparam int ROOT_W = 42;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_TABLE = 2'd1;
  localparam logic [1:0] STATUS_SHORT     = 2'd2;
  localparam logic [1:0] STATUS_UNUSED    = 2'd3;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic [47:0] cum;
    logic [31:0] slope;
    logic [31:0] dens;
    logic [31:0] absc;
  } entry_t;

endpackage

// ===== rtl/pwlcdf_ram.sv =====
`timescale 1ns / 1ps

module pwlcdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/pwlcdf_div.sv =====
`timescale 1ns / 1ps

module pwlcdf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pwlcdf_pkg::DIV_NW-1:0] num_i,
  input  logic [pwlcdf_pkg::DIV_DW-1:0] den_i,
  output logic                          done_o,
  output logic [pwlcdf_pkg::DIV_NW-1:0] quo_o
);

  localparam int NW = pwlcdf_pkg::DIV_NW;
  localparam int DW = pwlcdf_pkg::DIV_DW;
  localparam int CNTW = $clog2(NW);

  logic            run_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   den_q;
  logic [DW:0]     rem_sh;
  logic            ge;
  logic [DW:0]     rem_nx;

  always_comb begin
    rem_sh = {rem_q, quo_q[NW-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(NW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= rem_nx[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/piecewise_linear_inverse_cdf_sampler_core.sv =====
// First point of a table: written as it is accepted in idle. Later loads read the
// previous point, multiply, divide (64-bit divider) and write back. Sample: one bin
// per cycle in the downward search, 42-bit sqrt, 64-bit divider. Errors skip them.
// One item at a time; input ready only in idle. Output register holds one result.
// Reset (async, active low) clears the point counts and the output valid; the point
// memory is not cleared and is read only where written since the table restarted.
`timescale 1ns / 1ps

module piecewise_linear_inverse_cdf_sampler_core #(
  parameter int MAX_POINTS = pwlcdf_pkg::MAX_POINTS_DEF,
  parameter int NUM_TABLES = pwlcdf_pkg::NUM_TABLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // point_x [31:0], point_density [63:32], uniform_fraction [87:64]
  input  logic [87:0] s_axis_tdata_i,
  // func [0], table_select [2:1], first_point [3]
  input  logic [3:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // sample_value [31:0]
  output logic [31:0] m_axis_tdata_o,
  // status [1:0]
  output logic [1:0]  m_axis_tuser_o
);

  localparam int DEPTH  = NUM_TABLES * MAX_POINTS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int TW     = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int RAD_W  = pwlcdf_pkg::RAD_W;
  localparam int ROOT_W = pwlcdf_pkg::ROOT_W;
  localparam int SCW    = $clog2(ROOT_W);

  typedef enum logic [18:0] {
    S_IDLE    = 19'h00001,
    S_LD_RD   = 19'h00002,
    S_LD_MUL0 = 19'h00004,
    S_LD_MUL1 = 19'h00008,
    S_LD_DIV  = 19'h00010,
    S_LD_WR1  = 19'h00020,
    S_LD_WR2  = 19'h00040,
    S_SM_TOT  = 19'h00080,
    S_SM_Y0   = 19'h00100,
    S_SM_Y1   = 19'h00200,
    S_SR_CMP  = 19'h00400,
    S_SM_P0   = 19'h00800,
    S_SM_P1   = 19'h01000,
    S_SM_RAD  = 19'h02000,
    S_SM_SQRT = 19'h04000,
    S_SM_QST  = 19'h08000,
    S_SM_DIV  = 19'h10000,
    S_SM_FIN  = 19'h20000,
    S_OUT     = 19'h40000
  } state_e;

  typedef enum logic [2:0] {
    M_QUAD = 3'b001,
    M_LIN  = 3'b010,
    M_ZERO = 3'b100
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q;

  logic [CW-1:0] cnt_q [NUM_TABLES];

  // input decode
  logic              in_func, in_first, accept, tbl_ok;
  logic [1:0]        in_tbl;
  logic signed [31:0] in_x, in_f;
  logic [23:0]       in_u;
  logic [CW-1:0]     cnt_sel, ld_n;
  logic [AW-1:0]     base_in;

  // memory port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  pwlcdf_pkg::entry_t   ram_wdata, rd;
  logic [$bits(pwlcdf_pkg::entry_t)-1:0] rd_raw;

  // datapath registers
  logic [1:0]          tbl_q;
  logic signed [31:0]  x_q, f_q;
  logic [23:0]         u_q;
  logic [AW-1:0]       base_q;
  logic [CW-1:0]       n_q, j_q;
  pwlcdf_pkg::entry_t  prev_q, ent_q;
  logic signed [32:0]  dx_q, df_q, sum_q;
  logic [65:0]         acc_q;
  logic [31:0]         slope_q;
  logic [47:0]         cum_q;
  logic [47:0]         m_q;
  logic                tneg_q;
  logic [47:0]         p0_q;
  logic signed [49:0]  y_q;
  logic signed [50:0]  d_q;
  logic [81:0]         pp_q;
  logic [63:0]         f2_q;
  logic [RAD_W-1:0]    rad_q;
  logic [ROOT_W+2:0]   sq_rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [SCW-1:0]      sq_cnt_q;
  logic                neg_q;
  logic [63:0]         q_q;
  logic [31:0]         res_q;
  logic [1:0]          stat_q;
  logic                mvalid_q;
  logic [31:0]         mdata_q;
  logic [1:0]          muser_q;

  // divider
  logic                              div_start, div_done;
  logic [pwlcdf_pkg::DIV_NW-1:0]     div_num, div_quo;
  logic [pwlcdf_pkg::DIV_DW-1:0]     div_den;

  // combinational helpers
  logic [32:0]        dx_m, df_m, sum_m;
  logic [31:0]        slope_sat;
  logic [48:0]        area_m;
  logic signed [50:0] area_s, cum_sum;
  logic [47:0]        cum_new;
  logic [47:0]        p1;
  logic [48:0]        ym;
  logic               srch_stop;
  logic [31:0]        a_m, f_m;
  logic [49:0]        d_m;
  logic [47:0]        dcap;
  logic [82:0]        p2;
  logic               rad_same;
  logic [RAD_W-1:0]   rad_new;
  logic [ROOT_W+2:0]  sq_sh, sq_trial;
  logic               sq_ge;
  logic signed [43:0] diff;
  logic [42:0]        diff_m;
  logic [63:0]        dxm;
  logic signed [65:0] dxs, xsum;
  logic [31:0]        res_new;

  assign in_func  = s_axis_tuser_i[0];
  assign in_tbl   = s_axis_tuser_i[2:1];
  assign in_first = s_axis_tuser_i[3];
  assign in_x     = s_axis_tdata_i[31:0];
  assign in_f     = s_axis_tdata_i[63:32];
  assign in_u     = s_axis_tdata_i[87:64];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign tbl_ok  = {1'b0, in_tbl} < 3'(NUM_TABLES);
  assign cnt_sel = tbl_ok ? cnt_q[in_tbl[TW-1:0]] : '0;
  assign ld_n    = in_first ? '0 : cnt_sel;
  assign base_in = AW'(in_tbl) * AW'(MAX_POINTS);

  assign rd = pwlcdf_pkg::entry_t'(rd_raw);

  pwlcdf_ram #(
    .WIDTH($bits(pwlcdf_pkg::entry_t)),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rd_raw)
  );

  pwlcdf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // load arithmetic
  always_comb begin
    dx_m  = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
    df_m  = df_q[32] ? 33'(-df_q) : 33'(df_q);
    sum_m = sum_q[32] ? 33'(-sum_q) : 33'(sum_q);
    if (dx_q == '0) begin
      slope_sat = '0;
    end else if (df_q[32] != dx_q[32]) begin
      slope_sat = (div_quo > 64'h8000_0000) ? 32'h8000_0000 : 32'(-div_quo[31:0]);
    end else begin
      slope_sat = (div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
    end
    area_m  = acc_q[65:17];
    area_s  = (sum_q[32] != dx_q[32]) ? -$signed({2'b00, area_m})
                                      : $signed({2'b00, area_m});
    cum_sum = 51'($signed(prev_q.cum)) + area_s;
    if (cum_sum > 51'sh7FFF_FFFF_FFFF) begin
      cum_new = 48'h7FFF_FFFF_FFFF;
    end else if (cum_sum < -51'sh8000_0000_0000) begin
      cum_new = 48'h8000_0000_0000;
    end else begin
      cum_new = cum_sum[47:0];
    end
  end

  // sample arithmetic
  always_comb begin
    p1        = m_q[23:0] * u_q;
    ym        = 49'(p0_q) + 49'(p1[47:24]);
    srch_stop = (j_q == '0) || ($signed(rd.cum) <= y_q);
    a_m       = ent_q.slope[31] ? 32'(-ent_q.slope) : ent_q.slope;
    f_m       = ent_q.dens[31] ? 32'(-ent_q.dens) : ent_q.dens;
    d_m       = d_q[50] ? 50'(-d_q) : 50'(d_q);
    dcap      = (d_m > 50'h8000_0000_0000) ? 48'h8000_0000_0000 : d_m[47:0];
    p2        = {pp_q, 1'b0};
    rad_same  = (d_q == '0) || (ent_q.slope[31] == d_q[50]);
    if (rad_same) begin
      rad_new = RAD_W'(p2) + RAD_W'(f2_q);
    end else if (RAD_W'(p2) < RAD_W'(f2_q)) begin
      rad_new = RAD_W'(f2_q) - RAD_W'(p2);
    end else begin
      rad_new = '0;
    end
    sq_sh    = {sq_rem_q[ROOT_W:0], rad_q[RAD_W-1 -: 2]};
    sq_trial = (ROOT_W + 3)'({root_q, 2'b01});
    sq_ge    = sq_sh >= sq_trial;
    diff     = $signed({2'b00, root_q}) - 44'($signed(ent_q.dens));
    diff_m   = diff[43] ? 43'(-diff) : 43'(diff);
    case (mode_q)
      M_LIN:   dxm = (q_q > 64'h2_0000_0000) ? 64'h2_0000_0000 : q_q;
      M_QUAD:  dxm = q_q;
      default: dxm = '0;
    endcase
    dxs  = neg_q ? -$signed({2'b00, dxm}) : $signed({2'b00, dxm});
    xsum = 66'($signed(ent_q.absc)) + dxs;
    if (xsum > 66'sh7FFF_FFFF) begin
      res_new = 32'h7FFF_FFFF;
    end else if (xsum < -66'sh8000_0000) begin
      res_new = 32'h8000_0000;
    end else begin
      res_new = xsum[31:0];
    end
  end

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_q)
      S_LD_MUL0: begin
        div_start = 1'b1;
        div_num   = 64'({df_m, 16'h0000});
        div_den   = dx_m;
      end
      S_SM_RAD: begin
        div_start = (ent_q.slope == '0) && !ent_q.dens[31] && (ent_q.dens != '0);
        div_num   = {dcap, 16'h0000};
        div_den   = 33'(ent_q.dens);
      end
      S_SM_QST: begin
        div_start = 1'b1;
        div_num   = 64'({diff_m, 16'h0000});
        div_den   = 33'(a_m);
      end
      default: ;
    endcase
  end

  // memory port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = base_q + AW'(n_q);
    ram_wdata = '0;
    ram_raddr = base_q + AW'(j_q - CW'(1));
    case (state_q)
      S_IDLE: begin
        if (in_func == pwlcdf_pkg::FUNC_LOAD) begin
          ram_raddr = base_in + AW'(ld_n - CW'(1));
          if (accept && tbl_ok && (ld_n == '0)) begin
            ram_we          = 1'b1;
            ram_waddr       = base_in;
            ram_wdata.absc  = in_x;
            ram_wdata.dens  = in_f;
          end
        end else begin
          ram_raddr = base_in + AW'(cnt_sel - CW'(1));
        end
      end
      S_LD_WR1: begin
        ram_we          = 1'b1;
        ram_waddr       = base_q + AW'(n_q - CW'(1));
        ram_wdata       = prev_q;
        ram_wdata.slope = slope_q;
      end
      S_LD_WR2: begin
        ram_we         = 1'b1;
        ram_wdata.cum  = cum_q;
        ram_wdata.absc = x_q;
        ram_wdata.dens = f_q;
      end
      S_SM_Y1: ram_raddr = base_q + AW'(n_q - CW'(2));
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_func == pwlcdf_pkg::FUNC_LOAD) begin
            if (tbl_ok && (ld_n != '0) && (ld_n < CW'(MAX_POINTS))) state_d = S_LD_RD;
          end else if (!tbl_ok || (cnt_sel < CW'(2))) begin
            state_d = S_OUT;
          end else begin
            state_d = S_SM_TOT;
          end
        end
      end
      S_LD_RD:   state_d = S_LD_MUL0;
      S_LD_MUL0: state_d = S_LD_MUL1;
      S_LD_MUL1: state_d = S_LD_DIV;
      S_LD_DIV:  if (div_done) state_d = S_LD_WR1;
      S_LD_WR1:  state_d = S_LD_WR2;
      S_LD_WR2:  state_d = S_IDLE;
      S_SM_TOT:  state_d = S_SM_Y0;
      S_SM_Y0:   state_d = S_SM_Y1;
      S_SM_Y1:   state_d = S_SR_CMP;
      S_SR_CMP:  if (srch_stop) state_d = S_SM_P0;
      S_SM_P0:   state_d = S_SM_P1;
      S_SM_P1:   state_d = S_SM_RAD;
      S_SM_RAD: begin
        if (ent_q.slope != '0) begin
          state_d = S_SM_SQRT;
        end else if (div_start) begin
          state_d = S_SM_DIV;
        end else begin
          state_d = S_SM_FIN;
        end
      end
      S_SM_SQRT: if (sq_cnt_q == SCW'(ROOT_W - 1)) state_d = S_SM_QST;
      S_SM_QST:  state_d = S_SM_DIV;
      S_SM_DIV:  if (div_done) state_d = S_SM_FIN;
      S_SM_FIN:  state_d = S_OUT;
      S_OUT:     if (!mvalid_q || m_axis_tready_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mvalid_q <= 1'b0;
      sq_cnt_q <= '0;
      for (int i = 0; i < NUM_TABLES; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (m_axis_tready_i) begin
        mvalid_q <= 1'b0;
      end
      if ((state_q == S_OUT) && (!mvalid_q || m_axis_tready_i)) begin
        mvalid_q <= 1'b1;
      end
      if (state_q == S_SM_RAD) begin
        sq_cnt_q <= '0;
      end else if (state_q == S_SM_SQRT) begin
        sq_cnt_q <= sq_cnt_q + SCW'(1);
      end
      if (accept && (in_func == pwlcdf_pkg::FUNC_LOAD) && tbl_ok && (ld_n == '0)) begin
        cnt_q[in_tbl[TW-1:0]] <= CW'(1);
      end
      if (state_q == S_LD_WR2) begin
        cnt_q[tbl_q[TW-1:0]] <= n_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          tbl_q  <= in_tbl;
          x_q    <= in_x;
          f_q    <= in_f;
          u_q    <= in_u;
          base_q <= base_in;
          n_q    <= (in_func == pwlcdf_pkg::FUNC_LOAD) ? ld_n : cnt_sel;
          res_q  <= '0;
          stat_q <= tbl_ok ? pwlcdf_pkg::STATUS_SHORT : pwlcdf_pkg::STATUS_BAD_TABLE;
        end
      end
      S_LD_RD: begin
        prev_q <= rd;
        dx_q   <= 33'(x_q) - 33'($signed(rd.absc));
        df_q   <= 33'(f_q) - 33'($signed(rd.dens));
        sum_q  <= 33'(f_q) + 33'($signed(rd.dens));
      end
      S_LD_MUL0: acc_q <= 66'(sum_m * dx_m[16:0]);
      S_LD_MUL1: acc_q <= acc_q + (66'(sum_m * dx_m[32:17]) << 17);
      S_LD_DIV:  if (div_done) slope_q <= slope_sat;
      S_LD_WR1:  cum_q <= cum_new;
      S_SM_TOT: begin
        m_q    <= rd.cum[47] ? 48'(-rd.cum) : rd.cum;
        tneg_q <= rd.cum[47];
      end
      S_SM_Y0: p0_q <= m_q[47:24] * u_q;
      S_SM_Y1: begin
        y_q <= tneg_q ? -$signed({1'b0, ym}) : $signed({1'b0, ym});
        j_q <= n_q - CW'(2);
      end
      S_SR_CMP: begin
        if (srch_stop) begin
          ent_q <= rd;
          d_q   <= 51'(y_q) - 51'($signed(rd.cum));
        end else begin
          j_q <= j_q - CW'(1);
        end
      end
      S_SM_P0: begin
        pp_q <= 82'(a_m * d_m[24:0]);
        f2_q <= f_m * f_m;
      end
      S_SM_P1: pp_q <= pp_q + (82'(a_m * d_m[49:25]) << 25);
      S_SM_RAD: begin
        rad_q    <= rad_new;
        sq_rem_q <= '0;
        root_q   <= '0;
        neg_q    <= d_q[50];
        if (ent_q.slope != '0) begin
          mode_q <= M_QUAD;
        end else if (div_start) begin
          mode_q <= M_LIN;
        end else begin
          mode_q <= M_ZERO;
        end
      end
      S_SM_SQRT: begin
        rad_q    <= rad_q << 2;
        sq_rem_q <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
        root_q   <= {root_q[ROOT_W-2:0], sq_ge};
      end
      S_SM_QST: neg_q <= diff[43] != ent_q.slope[31];
      S_SM_DIV: if (div_done) q_q <= div_quo;
      S_SM_FIN: begin
        res_q  <= res_new;
        stat_q <= pwlcdf_pkg::STATUS_OK;
      end
      S_OUT: begin
        if (!mvalid_q || m_axis_tready_i) begin
          mdata_q <= res_q;
          muser_q <= stat_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tuser_o  = muser_q;

endmodule

// ===== rtl/pwlcdf_checker.sv =====
`timescale 1ns / 1ps
`include "piecewise_linear_inverse_cdf_sampler_core_macros.svh"

module pwlcdf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  `PWLCDF_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
  `PWLCDF_ASSERT(a_err_zero, m_axis_tvalid_o && (m_axis_tuser_o != pwlcdf_pkg::STATUS_OK) |-> m_axis_tdata_o == 32'd0)
  `PWLCDF_ASSERT(a_status_code, m_axis_tvalid_o |-> m_axis_tuser_o != pwlcdf_pkg::STATUS_UNUSED)
  `PWLCDF_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !m_axis_tvalid_o)

endmodule

bind piecewise_linear_inverse_cdf_sampler_core pwlcdf_checker u_pwlcdf_checker (.*);

// ===== bench/tb_piecewise_linear_inverse_cdf_sampler_core.sv =====
`timescale 1ns / 1ps

module tb_piecewise_linear_inverse_cdf_sampler_core;

  localparam int NTAB = pwlcdf_pkg::NUM_TABLES_DEF;
  localparam int NPTS = pwlcdf_pkg::MAX_POINTS_DEF;
  localparam longint X_MAX = 64'sd2147483647;
  localparam longint X_MIN = -64'sd2147483648;
  localparam longint CUM_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint CUM_MIN = -64'sh8000_0000_0000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 3000;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  status;
  } drawn_sample_t;

  class sampler_scoreboard;
    longint absc [NTAB][NPTS];
    longint dens [NTAB][NPTS];
    longint slope [NTAB][NPTS];
    longint cum [NTAB][NPTS];
    int count [NTAB];
    drawn_sample_t pending_draws[$];
    int errors, loads, draws, results;

    function new();
      for (int t = 0; t < NTAB; t++) begin
        count[t] = 0;
        for (int i = 0; i < NPTS; i++) begin
          absc[t][i] = 0;
          dens[t][i] = 0;
          slope[t][i] = 0;
          cum[t][i] = 0;
        end
      end
      errors = 0;
      loads = 0;
      draws = 0;
      results = 0;
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function bit [63:0] isqrt(bit [127:0] d);
      bit [127:0] r, c;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (128'd1 << b);
        if (c * c <= d) r = c;
      end
      return r[63:0];
    endfunction

    function void append_point(int t, bit first, longint x, longint f);
      int n;
      longint px, pf, dx, df, sm, area;
      bit [63:0] am, bm, prod;
      if (first) count[t] = 0;
      n = count[t];
      if (n >= NPTS) return;
      absc[t][n] = x;
      dens[t][n] = f;
      if (n == 0) begin
        cum[t][0] = 0;
      end else begin
        px = absc[t][n-1];
        pf = dens[t][n-1];
        dx = x - px;
        df = f - pf;
        sm = f + pf;
        slope[t][n-1] = (dx == 0) ? 0 : clamp((df * 65536) / dx, X_MIN, X_MAX);
        am = mag(sm);
        bm = mag(dx);
        prod = am * bm;
        area = longint'(prod >> 17);
        if ((sm < 0) != (dx < 0)) area = -area;
        cum[t][n] = clamp(cum[t][n-1] + area, CUM_MIN, CUM_MAX);
      end
      count[t] = n + 1;
    endfunction

    function longint inverse_cdf(int t, bit [23:0] uf);
      int n, j;
      longint total, y, xj, fj, aj, d, dx;
      bit [63:0] m, u, ym, dm, q;
      bit [127:0] f2, p, rad;
      n = count[t];
      total = cum[t][n-1];
      m = mag(total);
      u = 64'(uf);
      ym = (m >> 24) * u + (((m & 64'hFF_FFFF) * u) >> 24);
      y = total < 0 ? -longint'(ym) : longint'(ym);
      j = n - 2;
      while (j > 0 && cum[t][j] > y) j--;
      xj = absc[t][j];
      fj = dens[t][j];
      aj = slope[t][j];
      d = y - cum[t][j];
      dx = 0;
      if (aj != 0) begin
        f2 = 128'(mag(fj)) * 128'(mag(fj));
        p = (128'(mag(aj)) * 128'(mag(d))) << 1;
        if (d == 0 || ((aj < 0) == (d < 0))) rad = p + f2;
        else if (p < f2) rad = f2 - p;
        else rad = 0;
        dx = ((longint'(isqrt(rad)) - fj) * 65536) / aj;
      end else if (fj > 0) begin
        dm = mag(d);
        if (dm > (64'd1 << 47)) dm = 64'd1 << 47;
        q = (dm << 16) / 64'(fj);
        if (q > (64'd1 << 33)) q = 64'd1 << 33;
        dx = d < 0 ? -longint'(q) : longint'(q);
      end
      return clamp(xj + dx, X_MIN, X_MAX);
    endfunction

    function void note_item(bit func, bit [1:0] t, bit first, bit [31:0] x, bit [31:0] f,
                            bit [23:0] u);
      drawn_sample_t e;
      if (func == pwlcdf_pkg::FUNC_LOAD) begin
        loads++;
        if (t < NTAB) append_point(t, first, longint'(signed'(x)), longint'(signed'(f)));
        return;
      end
      draws++;
      if (t >= NTAB) begin
        e.value = 0;
        e.status = pwlcdf_pkg::STATUS_BAD_TABLE;
      end else if (count[t] < 2) begin
        e.value = 0;
        e.status = pwlcdf_pkg::STATUS_SHORT;
      end else begin
        e.value = 32'(inverse_cdf(t, u));
        e.status = pwlcdf_pkg::STATUS_OK;
      end
      pending_draws.push_back(e);
    endfunction

    function void check_result(logic [31:0] value, logic [1:0] status);
      drawn_sample_t e;
      results++;
      if (pending_draws.size() == 0) begin
        $error("unexpected result: sample_value %h status %0d", value, status);
        errors++;
        return;
      end
      e = pending_draws.pop_front();
      if (value !== e.value) begin
        $error("sample_value: expected %h actual %h", e.value, value);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, status);
        errors++;
      end
    endfunction

    function int pending();
      return pending_draws.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic [87:0] s_tdata;
  logic [3:0]  s_tuser;
  logic        m_ready;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  sampler_scoreboard sb;
  int src_idle;
  int snk_stall;
  int hold_req;
  int hold_seen;
  int hold_left;
  int quiet_cycles;
  int items_sent;

  piecewise_linear_inverse_cdf_sampler_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
      if ((m_axis_tvalid_o && m_ready) || (s_valid && s_axis_tready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_piecewise_linear_inverse_cdf_sampler_core: errors");
        $finish;
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= snk_stall);
    end
  end

  task automatic send_item(bit func, bit [1:0] t, bit first, bit [31:0] x, bit [31:0] f,
                           bit [23:0] u);
    while ($urandom_range(99) < src_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {u, f, x};
    s_tuser <= {first, t, func};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_item(func, t, first, x, f, u);
    items_sent++;
  endtask

  task automatic load(bit [1:0] t, bit first, bit [31:0] x, bit [31:0] f);
    send_item(pwlcdf_pkg::FUNC_LOAD, t, first, x, f, 24'($urandom));
  endtask

  task automatic draw(bit [1:0] t, bit [23:0] u);
    send_item(pwlcdf_pkg::FUNC_SAMPLE, t, 1'b0, $urandom, $urandom, u);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic bit [23:0] rand_fraction();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 24'h0;
    if (r == 1) return 24'hFF_FFFF;
    return 24'($urandom);
  endfunction

  task automatic random_group();
    int r, k;
    bit [1:0] t;
    bit [31:0] x, f;
    r = $urandom_range(99);
    if (r < 70) begin
      t = 2'($urandom_range(NTAB - 1));
      k = $urandom_range(2, 10);
      x = 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(99) < 85) f = $urandom_range(0, 1 << 20);
        else f = 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
        load(t, i == 0, x, f);
        x = x + ($urandom_range(9) == 0 ? 0 : $urandom_range(1, 1 << 18));
      end
      k = $urandom_range(1, 4);
      for (int i = 0; i < k; i++) draw(t, rand_fraction());
    end else if (r < 85) begin
      send_item(pwlcdf_pkg::FUNC_LOAD, 2'($urandom), 1'($urandom), $urandom, $urandom,
                24'($urandom));
    end else begin
      draw(2'($urandom), rand_fraction());
    end
  endtask

  task automatic random_phase(int idle, int stall, int n);
    int stop;
    src_idle = idle;
    snk_stall = stall;
    stop = items_sent + n;
    while (items_sent < stop) random_group();
    drain();
  endtask

  initial begin
    sb = new();
    src_idle = 0;
    snk_stall = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    items_sent = 0;
    rst_ni <= 1'b0;
    s_valid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    m_ready <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    draw(2'd0, 24'h80_0000);
    draw(2'd3, 24'h12_3456);
    load(2'd3, 1'b1, ONE_Q16, ONE_Q16);
    load(2'd0, 1'b1, 32'h0, ONE_Q16);
    draw(2'd0, 24'h40_0000);
    load(2'd0, 1'b0, ONE_Q16, ONE_Q16);
    load(2'd0, 1'b0, 32'h0002_0000, 32'h0003_0000);
    load(2'd0, 1'b0, 32'h0003_0000, 32'h0);
    draw(2'd0, 24'h0);
    draw(2'd0, 24'hFF_FFFF);
    draw(2'd0, 24'h80_0000);
    load(2'd1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    load(2'd1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    draw(2'd1, 24'hFF_FFFF);
    draw(2'd1, 24'h0);
    load(2'd2, 1'b1, 32'h0005_0000, 32'h0);
    load(2'd2, 1'b0, 32'h0005_0000, 32'h0);
    load(2'd2, 1'b0, 32'h000A_0000, 32'hFFFF_0000);
    load(2'd2, 1'b0, 32'h0004_0000, 32'h8000_0000);
    draw(2'd2, 24'h80_0000);
    draw(2'd2, 24'hFF_FFFF);
    drain();

    // output held off while the input keeps offering
    hold_req <= hold_req + 1;
    for (int i = 0; i < 8; i++) draw(2'd0, rand_fraction());
    drain();

    // fill one table past its capacity
    load(2'd2, 1'b1, 32'hFF00_0000, ONE_Q16);
    for (int i = 1; i <= NPTS; i++)
      load(2'd2, 1'b0, 32'hFF00_0000 + 32'(i) * ONE_Q16, ONE_Q16 + 32'((i % 7) << 14));
    draw(2'd2, 24'h0);
    draw(2'd2, 24'hFF_FFFF);
    draw(2'd2, 24'h55_5555);
    drain();

    random_phase(0, 0, 170);
    random_phase(83, 0, 170);
    random_phase(0, 83, 170);
    random_phase(25, 25, 170);

    drain();
    repeat (1000) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected samples never arrived", sb.pending());
      sb.errors++;
    end
    $display("covered %0d loads and %0d samples, %0d results checked", sb.loads, sb.draws,
             sb.results);
    $display("incl. bad/short tables, full table, extreme points, stalls and long hold-off");
    if (sb.errors == 0) begin
      $display("tb_piecewise_linear_inverse_cdf_sampler_core: clean");
    end else begin
      $display("tb_piecewise_linear_inverse_cdf_sampler_core: errors");
    end
    $finish;
  end

endmodule
